>>> sv/rotary_encoder_with_button_defines.svh
// Assertion macros for the rotary encoder block
`ifndef ROTARY_ENCODER_WITH_BUTTON_DEFINES_SVH
`define ROTARY_ENCODER_WITH_BUTTON_DEFINES_SVH

// same-cycle implication, clocked and gated by reset
`define REWB_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, clocked and gated by reset
`define REWB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/rewb_pkg.sv
// Types, constants and the phase table shared by the rotary encoder block
package rewb_pkg;

  localparam int TimerBits  = 16;
  localparam int FastFactor = 10;
  localparam int CfgBits    = 16;
  localparam int CmpW       = (TimerBits > CfgBits) ? TimerBits : CfgBits;

  localparam int FastPosInt = (FastFactor > 15) ? 15 : FastFactor;
  localparam int FastNegInt = (FastFactor > 16) ? 16 : FastFactor;

  localparam logic signed [4:0] TurnPos     = 5'sd1;
  localparam logic signed [4:0] TurnNeg     = -5'sd1;
  localparam logic signed [4:0] TurnPosFast = 5'(FastPosInt);
  localparam logic signed [4:0] TurnNegFast = 5'(-FastNegInt);

  typedef enum logic [1:0] {
    FuncPinA   = 2'd0,
    FuncPinB   = 2'd1,
    FuncSwitch = 2'd2,
    FuncTick   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PressShort   = 2'd0,
    PressLong    = 2'd1,
    PressRelease = 2'd2,
    PressHold    = 2'd3
  } press_e;

  typedef enum logic {
    EvTurn   = 1'b0,
    EvButton = 1'b1
  } event_e;

  typedef enum logic [1:0] {
    CfgVelEn   = 2'd0,
    CfgFastWin = 2'd1,
    CfgShort   = 2'd2,
    CfgLong    = 2'd3
  } cfg_idx_e;

  typedef logic [TimerBits-1:0] timer_t;

  typedef struct packed {
    func_e func;
    logic  level;
  } item_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } detent_t;

  typedef struct packed {
    logic   valid;
    press_e kind;
  } btn_t;

  function automatic logic signed [1:0] gray_move(input logic [3:0] idx);
    logic signed [1:0] r;
    unique case (idx)
      4'd2, 4'd4, 4'd11, 4'd13: r = 2'sd1;
      4'd1, 4'd7, 4'd8, 4'd14:  r = -2'sd1;
      default:                  r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic timer_t sat_inc(input timer_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

>>> sv/rewb_quad.sv
// Quadrature phase tracker and detent counter
module rewb_quad (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rewb_pkg::item_t item_i,
  output rewb_pkg::detent_t detent_o
);
  import rewb_pkg::*;

  logic              pin_a_q, pin_a_d;
  logic              pin_b_q, pin_b_d;
  logic [1:0]        phase_q, phase_d;
  logic signed [2:0] qs_q, qs_d;
  logic [1:0]        phase_new;
  logic signed [1:0] inc;
  logic signed [3:0] qs_sum;
  logic              pin_evt;

  assign pin_evt   = en_i && (item_i.func == FuncPinA || item_i.func == FuncPinB);
  assign pin_a_d   = (pin_evt && item_i.func == FuncPinA) ? item_i.level : pin_a_q;
  assign pin_b_d   = (pin_evt && item_i.func == FuncPinB) ? item_i.level : pin_b_q;
  assign phase_new = {pin_a_d, pin_b_d};
  assign inc       = gray_move({phase_q, phase_new});
  assign qs_sum    = {qs_q[2], qs_q} + {{2{inc[1]}}, inc};

  always_comb begin
    phase_d        = phase_q;
    qs_d           = qs_q;
    detent_o.valid = 1'b0;
    detent_o.neg   = qs_sum[3];
    if (pin_evt && inc != 2'sd0) begin
      phase_d = phase_new;
      if (qs_sum >= 4'sd4 || qs_sum <= -4'sd4) begin
        qs_d           = 3'sd0;
        detent_o.valid = 1'b1;
      end else begin
        qs_d = qs_sum[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_a_q <= 1'b1;
      pin_b_q <= 1'b1;
      phase_q <= 2'd3;
      qs_q    <= 3'sd0;
    end else begin
      pin_a_q <= pin_a_d;
      pin_b_q <= pin_b_d;
      phase_q <= phase_d;
      qs_q    <= qs_d;
    end
  end

endmodule

>>> sv/rewb_vel.sv
// Detent velocity tracker and turn scaling
module rewb_vel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  rewb_pkg::detent_t         detent_i,
  input  logic                      vel_en_i,
  input  logic [rewb_pkg::CfgBits-1:0] fast_win_i,
  output logic signed [4:0]         turn_o
);
  import rewb_pkg::*;

  timer_t since_q, since_d;
  logic   seen_q, seen_d;
  logic   dir_q, dir_d;
  logic   fast;

  assign fast = vel_en_i && seen_q && (detent_i.neg == dir_q)
             && (CmpW'(since_q) < CmpW'(fast_win_i));

  always_comb begin
    since_d = since_q;
    seen_d  = seen_q;
    dir_d   = dir_q;
    if (detent_i.neg) begin
      turn_o = fast ? TurnNegFast : TurnNeg;
    end else begin
      turn_o = fast ? TurnPosFast : TurnPos;
    end
    if (tick_i) begin
      since_d = sat_inc(since_q);
    end
    if (detent_i.valid) begin
      since_d = '0;
      seen_d  = 1'b1;
      if (vel_en_i) begin
        dir_d = detent_i.neg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q <= '0;
      seen_q  <= 1'b0;
      dir_q   <= 1'b0;
    end else begin
      since_q <= since_d;
      seen_q  <= seen_d;
      dir_q   <= dir_d;
    end
  end

endmodule

>>> sv/rewb_press.sv
// Switch hold timer and press classifier
module rewb_press (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  rewb_pkg::item_t           item_i,
  input  logic                      detent_i,
  input  logic [rewb_pkg::CfgBits-1:0] short_i,
  input  logic [rewb_pkg::CfgBits-1:0] long_i,
  output rewb_pkg::btn_t            btn_o
);
  import rewb_pkg::*;

  timer_t hold_q, hold_d, hold_inc;
  logic   armed_q, armed_d;
  logic   turned_q, turned_d;

  assign hold_inc = sat_inc(hold_q);

  always_comb begin
    hold_d     = hold_q;
    armed_d    = armed_q;
    turned_d   = turned_q || detent_i;
    btn_o.valid = 1'b0;
    btn_o.kind  = PressRelease;
    if (en_i && item_i.func == FuncSwitch) begin
      if (item_i.level) begin
        btn_o.valid = 1'b1;
        if (CmpW'(hold_q) < CmpW'(short_i)) begin
          btn_o.kind = PressShort;
          armed_d    = 1'b0;
        end else if (CmpW'(hold_q) > CmpW'(long_i) && !turned_q) begin
          btn_o.kind = PressLong;
        end
      end else begin
        hold_d   = '0;
        armed_d  = 1'b1;
        turned_d = 1'b0;
      end
    end else if (en_i && item_i.func == FuncTick) begin
      hold_d = hold_inc;
      if (armed_q && CmpW'(hold_inc) >= CmpW'(short_i)) begin
        armed_d     = 1'b0;
        btn_o.valid = 1'b1;
        btn_o.kind  = PressHold;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= '0;
      armed_q  <= 1'b0;
      turned_q <= 1'b0;
    end else begin
      hold_q   <= hold_d;
      armed_q  <= armed_d;
      turned_q <= turned_d;
    end
  end

endmodule

>>> sv/rotary_encoder_with_button.sv
// Each input word is registered in the input stage; its result is registered in the result register.
// One input word per cycle while the result register is not stalled; at most one result word per input.
// The input stage advances whenever the result register is empty or drained.
// Reset (async, active low) restores register defaults and idle decoder state.
// Rotary encoder decoder with push-switch classifier, top level
module rotary_encoder_with_button (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rewb_pkg::func_e              func_i,
  input  logic                         level_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rewb_pkg::event_e             event_kind_o,
  output logic signed [4:0]            turn_amount_o,
  output rewb_pkg::press_e             press_kind_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  rewb_pkg::cfg_idx_e           cfg_index_i,
  input  logic [rewb_pkg::CfgBits-1:0] cfg_data_i
);
  import rewb_pkg::*;

  logic               vel_en_q;
  logic [CfgBits-1:0] fast_win_q, short_q, long_q;
  logic               s1_valid_q;
  item_t              s1_item_q;
  logic               s1_adv, en, tick;
  detent_t            detent;
  btn_t               btn;
  logic signed [4:0]  turn;
  logic               out_valid_q;
  event_e             kind_q;
  logic signed [4:0]  amount_q;
  press_e             press_q;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign en          = s1_valid_q && s1_adv;
  assign tick        = en && s1_item_q.func == FuncTick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_en_q   <= 1'b0;
      fast_win_q <= CfgBits'(100);
      short_q    <= CfgBits'(500);
      long_q     <= CfgBits'(1500);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgVelEn:   vel_en_q   <= cfg_data_i[0];
        CfgFastWin: fast_win_q <= cfg_data_i;
        CfgShort:   short_q    <= cfg_data_i;
        CfgLong:    long_q     <= cfg_data_i;
        default:    vel_en_q   <= vel_en_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && (detent.valid || btn.valid);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= '{func: func_i, level: level_i};
    end
    if (en && detent.valid) begin
      kind_q   <= EvTurn;
      amount_q <= turn;
      press_q  <= PressShort;
    end else if (en && btn.valid) begin
      kind_q   <= EvButton;
      amount_q <= 5'sd0;
      press_q  <= btn.kind;
    end
  end

  rewb_quad u_quad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .item_i   (s1_item_q),
    .detent_o (detent)
  );

  rewb_vel u_vel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .detent_i   (detent),
    .vel_en_i   (vel_en_q),
    .fast_win_i (fast_win_q),
    .turn_o     (turn)
  );

  rewb_press u_press (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .item_i   (s1_item_q),
    .detent_i (detent.valid),
    .short_i  (short_q),
    .long_i   (long_q),
    .btn_o    (btn)
  );

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign turn_amount_o = amount_q;
  assign press_kind_o  = press_q;

endmodule

>>> sv/rewb_checker.sv
// Port-level checker for the rotary encoder block and its bind
`include "rotary_encoder_with_button_defines.svh"

module rewb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rewb_pkg::event_e  event_kind_o,
  input logic signed [4:0] turn_amount_o,
  input rewb_pkg::press_e  press_kind_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);
  import rewb_pkg::*;

  `REWB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o,
                    "result word dropped")
  `REWB_ASSERT_SAME(a_turn_nz, out_valid_o && event_kind_o == EvTurn,
                    turn_amount_o != 5'sd0 && press_kind_o == PressShort, "bad turn word")
  `REWB_ASSERT_SAME(a_btn_zero, out_valid_o && event_kind_o == EvButton,
                    turn_amount_o == 5'sd0, "button word carries a turn")
  `REWB_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
                    "input stalled without a waiting result")
  `REWB_ASSERT_SAME(a_cfg_ready, cfg_valid_i, cfg_ready_o, "config write refused")

endmodule

bind rotary_encoder_with_button rewb_checker u_rewb_checker (.*);
